>>> sv/fragment_depth_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// fragment depth blend unit assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_DEPTH_BLEND_UNIT_DEFINES_SVH
`define FRAGMENT_DEPTH_BLEND_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FDB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define FDB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_pkg
// shared types and constants of the fragment depth blend unit
// ----------------------------------------------------------------------------
package fdb_pkg;

   localparam int CHAN_W  = 9;    // q1.8 colour and alpha
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 24;   // red, green, blue bytes
   localparam int Z_W     = 24;   // signed q1.22 fragment depth
   localparam int IDX_W   = 16;

   localparam logic [CHAN_W-1:0] Q_ONE  = 9'd256;
   localparam logic [CHAN_W-1:0] Q_HALF = 9'd128;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_CALC  = 4'b0100,
      ST_WRITE = 4'b1000
   } fdb_state_type;

   typedef struct packed {
      logic passed;
      logic updated;
   } fdb_zstat_type;

endpackage

>>> sv/fdb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fdb_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_shade
// one colour channel: clamp, alpha blend with stored byte, byte conversion
// ----------------------------------------------------------------------------
module fdb_shade (
   input  logic                       clock,
   input  logic                       calc_en,
   input  logic [fdb_pkg::CHAN_W-1:0] src,
   input  logic [fdb_pkg::CHAN_W-1:0] alpha,
   input  logic [fdb_pkg::BYTE_W-1:0] dst,
   output logic [fdb_pkg::BYTE_W-1:0] byte_out
);
   import fdb_pkg::*;

   logic [CHAN_W-1:0]  src_c;
   logic [CHAN_W-1:0]  inv_a;
   logic [16:0]        prod_d;
   logic [16:0]        prod_s;
   logic [16:0]        sum;
   logic [CHAN_W-1:0]  blend_v;
   logic [CHAN_W-1:0]  v_in;
   logic [CHAN_W-1:0]  v_ff;
   logic [16:0]        scaled;
   logic [CHAN_W-1:0]  byte_wide;

   assign src_c = (src > Q_ONE) ? Q_ONE : src;
   assign inv_a = Q_ONE - alpha;

   // stored byte promoted to q1.8 is (d*257)>>8, which equals d for any byte
   assign prod_d = 17'(dst) * 17'(inv_a);
   assign prod_s = 17'(src_c) * 17'(alpha);
   assign sum    = prod_d + prod_s;

   assign blend_v = (sum[16:8] > Q_ONE) ? Q_ONE : sum[16:8];
   assign v_in    = (alpha > Q_ONE) ? src_c : blend_v;

   always_ff @(posedge clock) begin
      if (calc_en) begin
         v_ff <= v_in;
      end
   end

   // (v*255)>>8 as a shift and subtract, then saturate to a byte
   assign scaled    = {v_ff, 8'd0} - 17'(v_ff);
   assign byte_wide = scaled[16:8];
   assign byte_out  = (byte_wide > 9'd255) ? 8'd255 : byte_wide[BYTE_W-1:0];

endmodule

>>> sv/fdb_ztest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdb_ztest
// depth compare against the stored depth and saturated depth write value
// ----------------------------------------------------------------------------
module fdb_ztest #(
   parameter int DEPTH_BITS = 23
) (
   input  logic                            clock,
   input  logic                            calc_en,
   input  logic signed [fdb_pkg::Z_W-1:0]  frag_depth,
   input  logic [fdb_pkg::CHAN_W-1:0]      alpha,
   input  logic [DEPTH_BITS-1:0]           stored,
   output fdb_pkg::fdb_zstat_type          zstat,
   output logic [DEPTH_BITS-1:0]           wr_depth
);
   import fdb_pkg::*;

   localparam int CMP_W = ((DEPTH_BITS > Z_W) ? DEPTH_BITS : Z_W) + 2;

   logic signed [CMP_W-1:0] z_ext;
   logic signed [CMP_W-1:0] stored_ext;
   logic signed [CMP_W-1:0] far_ext;
   logic                    passed;
   logic [DEPTH_BITS-1:0]   sat_depth;
   fdb_zstat_type           zstat_ff;
   logic [DEPTH_BITS-1:0]   wr_depth_ff;

   assign z_ext      = CMP_W'(frag_depth);
   assign stored_ext = signed'(CMP_W'(stored));
   assign far_ext    = signed'(CMP_W'({DEPTH_BITS{1'b1}}));

   // negative depth is nearer than anything stored
   assign passed = z_ext < stored_ext;

   always_comb begin
      if (z_ext < 0) begin
         sat_depth = '0;
      end else if (z_ext > far_ext) begin
         sat_depth = '1;
      end else begin
         sat_depth = z_ext[DEPTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (calc_en) begin
         zstat_ff.passed  <= passed;
         zstat_ff.updated <= passed && (alpha > Q_HALF);
         wr_depth_ff      <= sat_depth;
      end
   end

   assign zstat    = zstat_ff;
   assign wr_depth = wr_depth_ff;

endmodule

>>> sv/fragment_depth_blend_unit.sv
`timescale 1ns / 1ps
`include "fragment_depth_blend_unit_defines.svh"
// ----------------------------------------------------------------------------
// fragment_depth_blend_unit
// depth test and alpha blend back end over a depth store and a colour store
// ----------------------------------------------------------------------------
// After reset the unit sweeps both stores, one pixel per cycle, setting every
// depth to the far maximum and every colour to black, with req_ready low.
// Then for each fragment the accept cycle issues the read of both stores, the
// next cycle blends and depth tests on the read data, and the write state
// writes the pixel back and loads the result register once that is free; the
// read-modify-write of the shared store entry serialises transactions. The
// result register lets a new fragment be accepted and worked on while the
// last result still waits on rsp_ready. PIXEL_COUNT must be a power of two;
// the pixel index wraps to its low bits.
// ----------------------------------------------------------------------------
module fragment_depth_blend_unit #(
   parameter int PIXEL_COUNT = 65536,
   parameter int DEPTH_BITS  = 23
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fdb_pkg::IDX_W-1:0]         req_pixel_index,
   input  logic signed [fdb_pkg::Z_W-1:0]    req_frag_depth,
   input  logic [fdb_pkg::CHAN_W-1:0]        req_src_red,
   input  logic [fdb_pkg::CHAN_W-1:0]        req_src_green,
   input  logic [fdb_pkg::CHAN_W-1:0]        req_src_blue,
   input  logic [fdb_pkg::CHAN_W-1:0]        req_src_alpha,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_depth_passed,
   output logic                              rsp_depth_updated,
   output logic [fdb_pkg::BYTE_W-1:0]        rsp_out_red,
   output logic [fdb_pkg::BYTE_W-1:0]        rsp_out_green,
   output logic [fdb_pkg::BYTE_W-1:0]        rsp_out_blue
);
   import fdb_pkg::*;

   localparam int ADDR_W = $clog2(PIXEL_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

   // control state
   fdb_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic rsp_valid_ff, rsp_valid_in;

   // captured fragment
   logic [ADDR_W-1:0]        addr_ff;
   logic signed [Z_W-1:0]    depth_ff;
   logic [CHAN_W-1:0]        red_ff, green_ff, blue_ff, alpha_ff;

   // result register
   logic                     passed_ff, updated_ff;
   logic [BYTE_W-1:0]        red_out_ff, green_out_ff, blue_out_ff;

   logic                     req_accept;
   logic                     clearing;
   logic                     calc_en;
   logic                     out_free;
   logic                     write_done;

   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic                     color_we, depth_we;
   logic [COLOR_W-1:0]       color_wdata, color_rdata;
   logic [DEPTH_BITS-1:0]    depth_wdata, depth_rdata;

   logic [BYTE_W-1:0]        red_byte, green_byte, blue_byte;
   fdb_zstat_type            zstat;
   logic [DEPTH_BITS-1:0]    z_wr_depth;

   assign clearing   = (state_ff == ST_CLEAR);
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign calc_en    = (state_ff == ST_CALC);
   // result register is free, or is emptied in this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign write_done = (state_ff == ST_WRITE) && out_free;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // fragment capture on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff  <= ADDR_W'(req_pixel_index);
         depth_ff <= req_frag_depth;
         red_ff   <= req_src_red;
         green_ff <= req_src_green;
         blue_ff  <= req_src_blue;
         alpha_ff <= req_src_alpha;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (write_done) begin
         passed_ff    <= zstat.passed;
         updated_ff   <= zstat.updated;
         red_out_ff   <= red_byte;
         green_out_ff <= green_byte;
         blue_out_ff  <= blue_byte;
      end
   end

   // store ports: read straight off the request so data lands in the calc cycle
   assign rd_addr     = ADDR_W'(req_pixel_index);
   assign wr_addr     = clearing ? clear_addr_ff : addr_ff;
   assign color_we    = clearing || (write_done && zstat.passed);
   assign depth_we    = clearing || (write_done && zstat.updated);
   assign color_wdata = clearing ? '0 : {red_byte, green_byte, blue_byte};
   assign depth_wdata = clearing ? '1 : z_wr_depth;

   fdb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PIXEL_COUNT)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_we),
      .wr_addr (wr_addr),
      .wr_data (color_wdata),
      .rd_addr (rd_addr),
      .rd_data (color_rdata)
   );

   fdb_ram #(
      .WIDTH (DEPTH_BITS),
      .DEPTH (PIXEL_COUNT)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (depth_we),
      .wr_addr (wr_addr),
      .wr_data (depth_wdata),
      .rd_addr (rd_addr),
      .rd_data (depth_rdata)
   );

   // colour channels, stored word is red in the high byte
   fdb_shade u_shade_red (
      .clock    (clock),
      .calc_en  (calc_en),
      .src      (red_ff),
      .alpha    (alpha_ff),
      .dst      (color_rdata[23:16]),
      .byte_out (red_byte)
   );

   fdb_shade u_shade_green (
      .clock    (clock),
      .calc_en  (calc_en),
      .src      (green_ff),
      .alpha    (alpha_ff),
      .dst      (color_rdata[15:8]),
      .byte_out (green_byte)
   );

   fdb_shade u_shade_blue (
      .clock    (clock),
      .calc_en  (calc_en),
      .src      (blue_ff),
      .alpha    (alpha_ff),
      .dst      (color_rdata[7:0]),
      .byte_out (blue_byte)
   );

   fdb_ztest #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_ztest (
      .clock      (clock),
      .calc_en    (calc_en),
      .frag_depth (depth_ff),
      .alpha      (alpha_ff),
      .stored     (depth_rdata),
      .zstat      (zstat),
      .wr_depth   (z_wr_depth)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth_passed  = passed_ff;
   assign rsp_depth_updated = updated_ff;
   assign rsp_out_red       = red_out_ff;
   assign rsp_out_green     = green_out_ff;
   assign rsp_out_blue      = blue_out_ff;

   // checks
   `FDB_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_ff), "state register not one-hot")
   `FDB_ASSERT_NEXT(a_accept_to_calc, req_accept, state_ff == ST_CALC,
                    "accepted transaction did not move to calc")
   `FDB_ASSERT_SAME(a_depth_needs_pass, depth_we && !clearing, color_we,
                    "depth written without colour write")
   `FDB_ASSERT_SAME(a_no_write_idle, state_ff == ST_IDLE || state_ff == ST_CALC,
                    !color_we && !depth_we, "store written outside clear or write-back")
   `FDB_ASSERT_NEXT(a_write_holds, state_ff == ST_WRITE && rsp_valid_ff && !rsp_ready,
                    state_ff == ST_WRITE && rsp_valid_ff, "write-back left while result stalled")

endmodule

>>> dv/fragment_depth_blend_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_depth_blend_unit_tb
// self-checking bench for the depth test and alpha blend back end: fragments
// are driven on the req channel, an in-bench model of the depth and colour
// stores predicts every rsp transaction, and results are checked in order
// ----------------------------------------------------------------------------
module fragment_depth_blend_unit_tb;
   import fdb_pkg::*;

   localparam int          PIXEL_COUNT = 65536;
   localparam int          DEPTH_BITS  = 23;
   localparam int unsigned FAR_DEPTH   = (1 << DEPTH_BITS) - 1;
   localparam int          Z_MAX       = (1 << (Z_W - 1)) - 1;
   localparam int unsigned ONE         = 32'(Q_ONE);
   localparam int unsigned HALF        = 32'(Q_HALF);
   localparam int          IDLE_PCT    = 32;
   localparam int          REPORT_MAX  = 10;

   // one fragment as it sits on the req ports
   typedef struct packed {
      logic [IDX_W-1:0]         pixel;
      logic signed [Z_W-1:0]    depth;
      logic [CHAN_W-1:0]        red;
      logic [CHAN_W-1:0]        green;
      logic [CHAN_W-1:0]        blue;
      logic [CHAN_W-1:0]        alpha;
   } fragment_type;

   // one rsp transaction
   typedef struct packed {
      fdb_zstat_type            zstat;
      logic [BYTE_W-1:0]        red;
      logic [BYTE_W-1:0]        green;
      logic [BYTE_W-1:0]        blue;
   } pixel_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [IDX_W-1:0]         req_pixel_index = '0;
   logic signed [Z_W-1:0]    req_frag_depth = '0;
   logic [CHAN_W-1:0]        req_src_red = '0;
   logic [CHAN_W-1:0]        req_src_green = '0;
   logic [CHAN_W-1:0]        req_src_blue = '0;
   logic [CHAN_W-1:0]        req_src_alpha = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_depth_passed;
   logic                     rsp_depth_updated;
   logic [BYTE_W-1:0]        rsp_out_red;
   logic [BYTE_W-1:0]        rsp_out_green;
   logic [BYTE_W-1:0]        rsp_out_blue;

   // bench copy of the two pixel stores
   logic [DEPTH_BITS-1:0]    depth_mem [PIXEL_COUNT];
   logic [COLOR_W-1:0]       color_mem [PIXEL_COUNT];

   // results owed by the unit, oldest first
   pixel_result_type         pixel_results_due [$];

   int                       mismatch_count = 0;
   int                       send_idle_pct = IDLE_PCT;
   int                       rsp_idle_pct = IDLE_PCT;
   int                       rsp_hold_request = 0;
   int                       rsp_hold_left = 0;

   fragment_depth_blend_unit #(
      .PIXEL_COUNT (PIXEL_COUNT),
      .DEPTH_BITS  (DEPTH_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_index   (req_pixel_index),
      .req_frag_depth    (req_frag_depth),
      .req_src_red       (req_src_red),
      .req_src_green     (req_src_green),
      .req_src_blue      (req_src_blue),
      .req_src_alpha     (req_src_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_depth_passed  (rsp_depth_passed),
      .rsp_depth_updated (rsp_depth_updated),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // depth test and blend of one fragment against the bench stores;
   // updates the stores exactly as the unit should
   function automatic pixel_result_type blend_and_depth_test(fragment_type f);
      pixel_result_type r;
      logic [COLOR_W-1:0] dst_rgb;
      int unsigned chan [3];
      int unsigned byte_out [3];
      int unsigned src, dst, dq, v, a;
      int z, k;
      dst_rgb = color_mem[f.pixel];
      chan[0] = 32'(f.red);
      chan[1] = 32'(f.green);
      chan[2] = 32'(f.blue);
      a = 32'(f.alpha);
      for (k = 0; k < 3; k++) begin
         src = (chan[k] > ONE) ? ONE : chan[k];
         // alpha above one means opaque copy of the clamped source
         if (a <= ONE) begin
            dst = 32'(dst_rgb[16 - 8 * k +: 8]);
            dq = (dst * 257) >> 8;
            v = (dq * (ONE - a) + src * a) >> 8;
            src = (v > ONE) ? ONE : v;
         end
         byte_out[k] = (src * 255) >> 8;
         if (byte_out[k] > 255) begin
            byte_out[k] = 255;
         end
      end
      z = int'(f.depth);
      r.zstat.passed = (z < int'({1'b0, depth_mem[f.pixel]}));
      r.zstat.updated = 1'b0;
      if (r.zstat.passed) begin
         // depth only written for mostly opaque fragments, saturated
         if (a > HALF) begin
            if (z < 0) begin
               depth_mem[f.pixel] = '0;
            end else if (z > int'(FAR_DEPTH)) begin
               depth_mem[f.pixel] = DEPTH_BITS'(FAR_DEPTH);
            end else begin
               depth_mem[f.pixel] = DEPTH_BITS'(z);
            end
            r.zstat.updated = 1'b1;
         end
         color_mem[f.pixel] = {byte_out[0][7:0], byte_out[1][7:0], byte_out[2][7:0]};
      end
      r.red = BYTE_W'(byte_out[0]);
      r.green = BYTE_W'(byte_out[1]);
      r.blue = BYTE_W'(byte_out[2]);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic fragment_type make_fragment(logic [IDX_W-1:0] pix,
                                                  logic signed [Z_W-1:0] z,
                                                  logic [CHAN_W-1:0] r,
                                                  logic [CHAN_W-1:0] g,
                                                  logic [CHAN_W-1:0] b,
                                                  logic [CHAN_W-1:0] a);
      fragment_type f;
      f.pixel = pix;
      f.depth = z;
      f.red = r;
      f.green = g;
      f.blue = b;
      f.alpha = a;
      return f;
   endfunction

   // mostly a few hot pixels at both ends of the range so that stored
   // colour and depth come into play, the rest anywhere
   function automatic logic [IDX_W-1:0] random_pixel();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         return IDX_W'($urandom_range(0, 15));
      end else if (sel < 7) begin
         return IDX_W'(16'hFFF0 | $urandom_range(0, 15));
      end
      return IDX_W'($urandom());
   endfunction

   function automatic logic [CHAN_W-1:0] random_channel();
      if ($urandom_range(0, 9) < 7) begin
         return CHAN_W'($urandom_range(0, ONE));
      end
      return CHAN_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [CHAN_W-1:0] random_alpha();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         case ($urandom_range(0, 5))
            0: return '0;
            1: return Q_HALF;
            2: return CHAN_W'(Q_HALF + 1);
            3: return Q_ONE;
            4: return CHAN_W'(Q_ONE + 1);
            default: return '1;
         endcase
      end else if (sel < 7) begin
         return CHAN_W'($urandom_range(0, ONE));
      end
      return CHAN_W'($urandom_range(0, 511));
   endfunction

   // depth picked around the stored depth of the pixel so that the test
   // goes both ways, with ties, negatives and full-range noise mixed in
   function automatic fragment_type random_fragment_at(logic [IDX_W-1:0] pix);
      fragment_type f;
      int sel, z;
      sel = $urandom_range(0, 19);
      z = int'({1'b0, depth_mem[pix]});
      if (sel < 10) begin
         z = z + $urandom_range(0, 600) - 300;
         if (z > Z_MAX) begin
            z = Z_MAX;
         end
      end else if (sel < 15 && sel >= 12) begin
         z = -int'($urandom_range(1, Z_MAX + 1));
      end else if (sel >= 15) begin
         z = $urandom();
      end
      f = make_fragment(pix, Z_W'(z), random_channel(), random_channel(),
                        random_channel(), random_alpha());
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // sender: one fragment transaction, random idle cycles ahead of it
   // ---------------------------------------------------------------------
   task automatic send_fragment(input fragment_type f);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_index <= f.pixel;
      req_frag_depth <= f.depth;
      req_src_red <= f.red;
      req_src_green <= f.green;
      req_src_blue <= f.blue;
      req_src_alpha <= f.alpha;
      // values sampled here are the ones seen at the edge
      do begin
         @(posedge clock);
      end while (!req_ready);
      pixel_results_due.push_back(blend_and_depth_test(f));
   endtask

   // sender goes quiet until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pixel_results_due.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // receiver: random stalls, or a long hold-off when one is requested
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // result checker: every rsp transaction against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.zstat.passed = rsp_depth_passed;
         got.zstat.updated = rsp_depth_updated;
         got.red = rsp_out_red;
         got.green = rsp_out_green;
         got.blue = rsp_out_blue;
         if (pixel_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("%0t: result with none owed: pass %0b upd %0b rgb %0d %0d %0d",
                        $time, got.zstat.passed, got.zstat.updated,
                        got.red, got.green, got.blue);
            end
         end else begin
            want = pixel_results_due.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("%0t: exp/act p %0b/%0b u %0b/%0b r %0d/%0d g %0d/%0d b %0d/%0d",
                           $time, want.zstat.passed, got.zstat.passed,
                           want.zstat.updated, got.zstat.updated,
                           want.red, got.red, want.green, got.green,
                           want.blue, got.blue);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // field extremes, alpha thresholds, depth ties, negative depth
   task automatic test_directed_corners();
      send_fragment(make_fragment(16'h0000, 24'sd0, 9'd0, 9'd0, 9'd0, 9'd0));
      // nearest possible depth, opaque, overrange colour
      send_fragment(make_fragment(16'hFFFF, 24'sh800000, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF));
      // farthest depth behind the stored zero, fails
      send_fragment(make_fragment(16'hFFFF, 24'sh7FFFFF, 9'd0, 9'd0, 9'd0, Q_ONE));
      // negative depth still nearer than zero, alpha at one half
      send_fragment(make_fragment(16'hFFFF, -24'sd1, 9'd100, 9'd200, 9'd300, Q_HALF));
      // tie with the far reset value
      send_fragment(make_fragment(16'h0001, Z_W'(FAR_DEPTH), 9'd10, 9'd20, 9'd30, Q_ONE));
      send_fragment(make_fragment(16'h0002, Z_W'(FAR_DEPTH - 1), 9'd256, 9'd256, 9'd256,
                                  Q_HALF));
      send_fragment(make_fragment(16'h0002, Z_W'(FAR_DEPTH - 1), 9'd0, 9'd128, 9'd256,
                                  CHAN_W'(Q_HALF + 1)));
      send_fragment(make_fragment(16'h0002, Z_W'(FAR_DEPTH - 1), 9'h1FF, 9'd0, 9'h1FF,
                                  CHAN_W'(Q_ONE + 1)));
      send_fragment(make_fragment(16'h0003, 24'sd1000, 9'd257, 9'd256, 9'd255, Q_ONE));
      // alpha just above one, no blend
      send_fragment(make_fragment(16'h0003, 24'sd999, 9'd300, 9'd100, 9'd1,
                                  CHAN_W'(Q_ONE + 1)));
      send_fragment(make_fragment(16'h0003, 24'sd998, 9'd17, 9'd33, 9'd65, 9'd1));
      // alternating bit patterns
      send_fragment(make_fragment(16'h5555, 24'sh555555, 9'h155, 9'h0AA, 9'h155, 9'h0AA));
      send_fragment(make_fragment(16'hAAAA, 24'shAAAAAA, 9'h0AA, 9'h155, 9'h0AA, 9'h155));
      send_fragment(make_fragment(16'h5555, 24'sh555554, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(16'h8000, 24'sh7FFFFE, 9'h100, 9'h080, 9'h001, 9'h0FF));
   endtask

   // back-to-back fragments on one pixel with no idling on either side,
   // each one reads what the one before just wrote
   task automatic test_same_pixel_bursts();
      logic [IDX_W-1:0] pix;
      int burst, n;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      for (burst = 0; burst < 4; burst++) begin
         pix = random_pixel();
         for (n = 0; n < 15; n++) begin
            send_fragment(random_fragment_at(pix));
         end
      end
      send_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   // receiver holds off long enough for the unit to fill and stall req,
   // then the sender waits until all results are back
   task automatic test_result_backpressure();
      int n;
      send_idle_pct = 0;
      rsp_hold_request = 200;
      for (n = 0; n < 40; n++) begin
         send_fragment(random_fragment_at(random_pixel()));
      end
      drain_results();
      send_idle_pct = IDLE_PCT;
   endtask

   // bulk random traffic with a stretch free of idling and occasional
   // full drains
   task automatic test_random_traffic();
      int n;
      for (n = 0; n < 740; n++) begin
         if (n == 300) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (n == 420) begin
            send_idle_pct = IDLE_PCT;
            rsp_idle_pct = IDLE_PCT;
         end else if ($urandom_range(0, 99) == 0) begin
            drain_results();
         end
         send_fragment(random_fragment_at(random_pixel()));
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int i;
      // reset image of the stores: far depth, black colour
      for (i = 0; i < PIXEL_COUNT; i++) begin
         depth_mem[i] = DEPTH_BITS'(FAR_DEPTH);
         color_mem[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the store clear after reset holds req_ready low; send waits it out
      test_directed_corners();
      test_same_pixel_bursts();
      test_result_backpressure();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pixel_results_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, well past the store clear plus the slowest traffic
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
